// ===== sv/straight_alpha_over_blend_defines.svh =====
// Assertion macros for the straight alpha blend block.
// Bodies are compiled out when SYNTHESIS is defined.
`ifndef STRAIGHT_ALPHA_OVER_BLEND_DEFINES_SVH
`define STRAIGHT_ALPHA_OVER_BLEND_DEFINES_SVH
`ifndef SYNTHESIS
`define SAOB_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("saob: assertion failed");
`define SAOB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
		else $error("saob: assertion failed");
`else
`define SAOB_ASSERT(lbl, clk, rstn, prop)
`define SAOB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/saob_pkg.sv =====
`timescale 1ns / 1ps
package saob_pkg;

	localparam logic [7:0]  CH_MAX    = 8'd255;
	// floor(x / 255) == (x * 0x8081) >> 23 for any 16-bit x
	localparam logic [15:0] RECIP_255 = 16'h8081;
	localparam int unsigned RECIP_SHIFT = 23;
	localparam int unsigned NUM_CH = 3;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pix_t;

	typedef struct packed {
		logic [23:0] rem;
		logic [1:0]  q;
	} div_res_t;

	// Two restoring-division steps, quotient bits bit_hi and bit_hi-1.
	function automatic div_res_t div2(input logic [23:0] rem, input logic [15:0] den,
		input int unsigned bit_hi);
		logic [23:0] r;
		logic [23:0] trial;
		div_res_t    res;
		r     = rem;
		trial = 24'(den) << bit_hi;
		if (r >= trial) begin
			r        = r - trial;
			res.q[1] = 1'b1;
		end else begin
			res.q[1] = 1'b0;
		end
		trial = 24'(den) << (bit_hi - 1);
		if (r >= trial) begin
			r        = r - trial;
			res.q[0] = 1'b1;
		end else begin
			res.q[0] = 1'b0;
		end
		res.rem = r;
		return res;
	endfunction

endpackage

// ===== sv/saob_if.sv =====
`timescale 1ns / 1ps
interface saob_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] src_alpha;
	logic [7:0] dst_red;
	logic [7:0] dst_green;
	logic [7:0] dst_blue;
	logic [7:0] dst_alpha;

	modport source (output valid, output src_red, output src_green, output src_blue,
		output src_alpha, output dst_red, output dst_green, output dst_blue,
		output dst_alpha, input ready);
	modport sink (input valid, input src_red, input src_green, input src_blue,
		input src_alpha, input dst_red, input dst_green, input dst_blue,
		input dst_alpha, output ready);
endinterface

interface saob_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_alpha, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_alpha, output ready);
endinterface

// ===== sv/straight_alpha_over_blend.sv =====
// Straight-alpha Porter-Duff "over" blend, RGBA8 in, RGBA8 out.
// Path: an accepted input moves through registered stages s1 to s6, and out
// valid is the s6 valid bit; output back-pressure can stall the pipeline.
// Throughput: 1 pixel per cycle unless stalled; the six-stage pipeline (two
// products, then four 2-bit restoring division stages) accepts a pixel each clock.
// Reset: arst_n clears all stage valid bits asynchronously; data is not reset.
`timescale 1ns / 1ps
`include "straight_alpha_over_blend_defines.svh"
module straight_alpha_over_blend (
	input  logic        clk,
	input  logic        arst_n,
	saob_in_if.sink     pix_in,
	saob_out_if.source  pix_out
);
	import saob_pkg::*;

	// Stage map
	//   s1 : sa*255, da*(255-sa), sc*sa per channel
	//   s2 : den = sa*255 + da*(255-sa), numerator per channel (24 bit)
	//   s3 : quotient bits 7:6, alpha = den/255 by reciprocal multiply
	//   s4 : quotient bits 5:4
	//   s5 : quotient bits 3:2
	//   s6 : quotient bits 1:0, pass-through select, output register
	// Remainder stays below den << (next quotient bit + 1), so it narrows by
	// two bits per stage.

	// Stage enables: a stage loads when empty or when the one after it moves.
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_comb begin
		en_s6 = !v_s6 || pix_out.ready;
		en_s5 = !v_s5 || en_s6;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		en_s2 = !v_s2 || en_s3;
		en_s1 = !v_s1 || en_s2;
	end

	assign pix_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_in.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: products ----------------
	logic [7:0]  src_c  [NUM_CH];
	logic [7:0]  inv_sa;
	logic        pass_s1;
	logic [15:0] sa255_s1;
	logic [15:0] t_s1;
	logic [15:0] ps_s1  [NUM_CH];
	pix_t        dst_s1;

	always_comb begin
		src_c[0] = pix_in.src_red;
		src_c[1] = pix_in.src_green;
		src_c[2] = pix_in.src_blue;
		inv_sa   = CH_MAX - pix_in.src_alpha;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			// transparent source: destination goes through untouched
			pass_s1  <= (pix_in.src_alpha == 8'd0);
			sa255_s1 <= {pix_in.src_alpha, 8'h00} - {8'h00, pix_in.src_alpha};
			t_s1     <= 16'(pix_in.dst_alpha) * 16'(inv_sa);
			for (int k = 0; k < NUM_CH; k++) begin
				ps_s1[k] <= 16'(src_c[k]) * 16'(pix_in.src_alpha);
			end
			dst_s1.r <= pix_in.dst_red;
			dst_s1.g <= pix_in.dst_green;
			dst_s1.b <= pix_in.dst_blue;
			dst_s1.a <= pix_in.dst_alpha;
		end
	end

	// ---------------- stage 2: numerator and denominator ----------------
	logic [7:0]  dc_s1  [NUM_CH];
	logic        pass_s2;
	logic [15:0] den_s2;
	logic [23:0] num_s2 [NUM_CH];
	pix_t        dst_s2;

	always_comb begin
		dc_s1[0] = dst_s1.r;
		dc_s1[1] = dst_s1.g;
		dc_s1[2] = dst_s1.b;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pass_s2 <= pass_s1;
			// max 65025, fits 16 bits
			den_s2  <= sa255_s1 + t_s1;
			for (int k = 0; k < NUM_CH; k++) begin
				// sc*sa*255 + dc*da*(255-sa), max 255*65025
				num_s2[k] <= (24'({ps_s1[k], 8'h00}) - 24'(ps_s1[k]))
					+ 24'(dc_s1[k]) * 24'(t_s1);
			end
			dst_s2 <= dst_s1;
		end
	end

	// ---------------- stage 3: bits 7:6, alpha ----------------
	logic [31:0] alpha_prod;
	div_res_t    dr_s3  [NUM_CH];
	logic        pass_s3;
	logic [15:0] den_s3;
	logic [21:0] rem_s3 [NUM_CH];
	logic [1:0]  q_s3   [NUM_CH];
	logic [7:0]  alpha_s3;
	pix_t        dst_s3;

	always_comb begin
		alpha_prod = 32'(den_s2) * 32'(RECIP_255);
		for (int k = 0; k < NUM_CH; k++) begin
			dr_s3[k] = div2(num_s2[k], den_s2, 7);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pass_s3  <= pass_s2;
			den_s3   <= den_s2;
			alpha_s3 <= alpha_prod[RECIP_SHIFT +: 8];
			for (int k = 0; k < NUM_CH; k++) begin
				rem_s3[k] <= dr_s3[k].rem[21:0];
				q_s3[k]   <= dr_s3[k].q;
			end
			dst_s3 <= dst_s2;
		end
	end

	// ---------------- stage 4: bits 5:4 ----------------
	div_res_t    dr_s4  [NUM_CH];
	logic        pass_s4;
	logic [15:0] den_s4;
	logic [19:0] rem_s4 [NUM_CH];
	logic [3:0]  q_s4   [NUM_CH];
	logic [7:0]  alpha_s4;
	pix_t        dst_s4;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			dr_s4[k] = div2(24'(rem_s3[k]), den_s3, 5);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			pass_s4  <= pass_s3;
			den_s4   <= den_s3;
			alpha_s4 <= alpha_s3;
			for (int k = 0; k < NUM_CH; k++) begin
				rem_s4[k] <= dr_s4[k].rem[19:0];
				q_s4[k]   <= {q_s3[k], dr_s4[k].q};
			end
			dst_s4 <= dst_s3;
		end
	end

	// ---------------- stage 5: bits 3:2 ----------------
	div_res_t    dr_s5  [NUM_CH];
	logic        pass_s5;
	logic [15:0] den_s5;
	logic [17:0] rem_s5 [NUM_CH];
	logic [5:0]  q_s5   [NUM_CH];
	logic [7:0]  alpha_s5;
	pix_t        dst_s5;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			dr_s5[k] = div2(24'(rem_s4[k]), den_s4, 3);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			pass_s5  <= pass_s4;
			den_s5   <= den_s4;
			alpha_s5 <= alpha_s4;
			for (int k = 0; k < NUM_CH; k++) begin
				rem_s5[k] <= dr_s5[k].rem[17:0];
				q_s5[k]   <= {q_s4[k], dr_s5[k].q};
			end
			dst_s5 <= dst_s4;
		end
	end

	// ---------------- stage 6: bits 1:0, select, output ----------------
	div_res_t    dr_s6  [NUM_CH];
	logic [7:0]  q_fin  [NUM_CH];
	logic        pass_s6;
	pix_t        res_s6;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			dr_s6[k] = div2(24'(rem_s5[k]), den_s5, 1);
			q_fin[k] = {q_s5[k], dr_s6[k].q};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pass_s6 <= pass_s5;
			if (pass_s5) begin
				res_s6 <= dst_s5;
			end else begin
				// num <= 255*den, so the quotient never needs clamping
				res_s6.r <= q_fin[0];
				res_s6.g <= q_fin[1];
				res_s6.b <= q_fin[2];
				res_s6.a <= alpha_s5;
			end
		end
	end

	assign pix_out.valid     = v_s6;
	assign pix_out.out_red   = res_s6.r;
	assign pix_out.out_green = res_s6.g;
	assign pix_out.out_blue  = res_s6.b;
	assign pix_out.out_alpha = res_s6.a;

	// ---------------- checks ----------------
	// input stalls only when every stage holds a transaction
	`SAOB_ASSERT(a_stall_full, clk, arst_n,
		!pix_in.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
	// transparent source is flagged for pass-through on entry
	`SAOB_ASSERT_NEXT(a_pass_entry, clk, arst_n,
		pix_in.valid && pix_in.ready && (pix_in.src_alpha == 8'd0), v_s1 && pass_s1)
	// before the last step the remainder stays below 4*den
	`SAOB_ASSERT(a_rem_bound, clk, arst_n,
		(v_s5 && !pass_s5) |-> ((rem_s5[0] < (18'(den_s5) << 2))
		&& (rem_s5[1] < (18'(den_s5) << 2)) && (rem_s5[2] < (18'(den_s5) << 2))))
	// a blended pixel with nonzero source alpha has nonzero coverage
	`SAOB_ASSERT(a_alpha_nz, clk, arst_n,
		(v_s6 && !pass_s6) |-> (pix_out.out_alpha != 8'd0))

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Porter-Duff "over" check for straight_alpha_over_blend.
// A short table of corner pixels runs first, then about 1100 random pixel
// pairs with random idling and stalling on both channels.
module testbench;
	import saob_pkg::*;

	localparam int unsigned RAND_PIXELS  = 1128;
	localparam int unsigned HOLD_OFF     = 64;   // long output stall, in cycles
	localparam int unsigned BURST_PIXELS = 100;  // back-to-back pixels during the stall
	localparam int unsigned SETTLE       = 12;   // extra wait after the last expected pixel, in cycles
	localparam int unsigned LIMIT_NS     = 5_000_000;

	// One directed row. want is only meaningful when fixed is set; the other
	// rows get their result from the blend predictor below.
	typedef struct packed {
		pix_t src;
		pix_t dst;
		pix_t want;
		logic fixed;
	} blend_row_t;

	localparam int unsigned NUM_ROWS = 22;

	// pixel words are {r, g, b, a}
	localparam blend_row_t CORNER_ROWS [NUM_ROWS] = '{
		// nothing anywhere: zero coverage, destination comes back
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
		// transparent source over an arbitrary destination
		'{32'hFFFF_FF00, 32'h0C22_384E, 32'h0C22_384E, 1'b1},
		'{32'h8040_2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
		// transparent over transparent: den is zero as well
		'{32'hFFFF_FF00, 32'h0000_0000, 32'h0000_0000, 1'b1},
		// opaque source wins outright
		'{32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1},
		'{32'h0000_00FF, 32'hFFFF_FFFF, 32'h0000_00FF, 1'b1},
		'{32'h0180_FEFF, 32'hA55A_C33C, 32'h0180_FEFF, 1'b1},
		// transparent destination: source comes through with its own alpha
		'{32'hC864_3201, 32'hFFFF_FF00, 32'hC864_3201, 1'b1},
		'{32'h1122_3380, 32'h0000_0000, 32'h1122_3380, 1'b1},
		'{32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFE, 1'b1},
		// partial coverage on both sides, predicted
		'{32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 1'b0},
		'{32'hFFFF_FF01, 32'h0000_00FF, 32'h0, 1'b0},
		// closest the quotient gets to the clamp
		'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0, 1'b0},
		'{32'hFFFF_FF01, 32'hFFFF_FF01, 32'h0, 1'b0},
		'{32'h0000_00FE, 32'hFFFF_FFFF, 32'h0, 1'b0},
		'{32'h8080_8080, 32'h8080_8080, 32'h0, 1'b0},
		'{32'h0000_0001, 32'h0000_0001, 32'h0, 1'b0},
		'{32'h00FF_0080, 32'hFF00_FF80, 32'h0, 1'b0},
		'{32'h7F7F_7F7F, 32'h8080_8080, 32'h0, 1'b0},
		'{32'hFF00_FF7F, 32'h00FF_00FF, 32'h0, 1'b0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 1'b0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	saob_in_if  pix_in ();
	saob_out_if pix_out ();

	straight_alpha_over_blend uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.pix_out(pix_out)
	);

	pix_t        blended_q [$];   // expected output pixels, oldest first
	int unsigned mismatches = 0;
	bit          quiet = 1'b0;        // no idling on either side while set
	bit          hold_off_req = 1'b0; // sender asks the drain side for a long stall

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Blend predictor: exact integer form of straight-alpha "over".
	// ---------------------------------------------------------------
	function automatic logic [7:0] mix_channel(input logic [7:0] sc, input logic [7:0] dc,
		input int unsigned sa, input int unsigned da, input int unsigned coverage);
		int unsigned num;
		int unsigned quo;
		num = int'(sc) * sa * 255 + int'(dc) * da * (255 - sa);
		quo = num / coverage;
		return (quo > 255) ? CH_MAX : 8'(quo);
	endfunction

	function automatic pix_t over_blend(input pix_t src, input pix_t dst);
		int unsigned sa;
		int unsigned da;
		int unsigned coverage;
		pix_t        res;
		sa = 32'(src.a);
		da = 32'(dst.a);
		coverage = sa * 255 + da * (255 - sa);
		// transparent source or no coverage at all: destination passes
		if (sa == 0 || coverage == 0)
			return dst;
		res.r = mix_channel(src.r, dst.r, sa, da, coverage);
		res.g = mix_channel(src.g, dst.g, sa, da, coverage);
		res.b = mix_channel(src.b, dst.b, sa, da, coverage);
		res.a = (coverage / 255 > 255) ? CH_MAX : 8'(coverage / 255);
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Random helpers
	// ---------------------------------------------------------------
	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Alpha leans on the values where the math changes character.
	function automatic logic [7:0] pick_alpha();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return 8'h00;
		if (roll < 20)
			return 8'hFF;
		if (roll < 26)
			return 8'($urandom_range(1, 3));
		if (roll < 32)
			return 8'($urandom_range(252, 254));
		return 8'($urandom);
	endfunction

	function automatic pix_t rand_pixel();
		pix_t p;
		p.r = 8'($urandom);
		p.g = 8'($urandom);
		p.b = 8'($urandom);
		p.a = pick_alpha();
		return p;
	endfunction

	// ---------------------------------------------------------------
	// Source side. Inputs change on the falling edge only.
	// ---------------------------------------------------------------
	task automatic drive_pixels(input pix_t src, input pix_t dst);
		pix_in.src_red   <= src.r;
		pix_in.src_green <= src.g;
		pix_in.src_blue  <= src.b;
		pix_in.src_alpha <= src.a;
		pix_in.dst_red   <= dst.r;
		pix_in.dst_green <= dst.g;
		pix_in.dst_blue  <= dst.b;
		pix_in.dst_alpha <= dst.a;
	endtask

	// Present one pixel pair and hold it until the transaction completes.
	// The expected result is queued at the accepting edge.
	task automatic offer_pixel(input pix_t src, input pix_t dst, input pix_t want,
		input logic fixed);
		@(negedge clk);
		pix_in.valid <= 1'b1;
		drive_pixels(src, dst);
		do
			@(posedge clk);
		while (!pix_in.ready);
		blended_q.push_back(fixed ? want : over_blend(src, dst));
	endtask

	// Drop valid for an idle gap of length n; the payload is scrambled while idle.
	task automatic idle_sender(input int unsigned n);
		if (n == 0)
			return;
		@(negedge clk);
		pix_in.valid <= 1'b0;
		drive_pixels(rand_pixel(), rand_pixel());
		repeat (n - 1) @(negedge clk);
	endtask

	initial begin : source_side
		int unsigned burst_left;
		blend_row_t  row;
		pix_in.valid     = 1'b0;
		pix_in.src_red   = 8'h00;
		pix_in.src_green = 8'h00;
		pix_in.src_blue  = 8'h00;
		pix_in.src_alpha = 8'h00;
		pix_in.dst_red   = 8'h00;
		pix_in.dst_green = 8'h00;
		pix_in.dst_blue  = 8'h00;
		pix_in.dst_alpha = 8'h00;
		burst_left = 0;

		// hold reset, then release it on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner table
		for (int unsigned i = 0; i < NUM_ROWS; i++) begin
			row = CORNER_ROWS[i];
			offer_pixel(row.src, row.dst, row.want, row.fixed);
			idle_sender(idle_len());
		end

		// random pixel pairs
		for (int unsigned n = 0; n < RAND_PIXELS; n++) begin
			if (n == 150) begin
				// drain side stalls for a long stretch while we keep pushing,
				// so the pipeline fills and backs up into the input
				hold_off_req = 1'b1;
				burst_left = BURST_PIXELS;
			end
			if (n == 500) begin
				// let the pipeline run completely dry before going on
				@(negedge clk);
				pix_in.valid <= 1'b0;
				while (blended_q.size() != 0)
					@(posedge clk);
			end
			if (n == 700)
				quiet = 1'b1;
			if (n == 850)
				quiet = 1'b0;

			offer_pixel(rand_pixel(), rand_pixel(), '0, 1'b0);
			if (burst_left > 0)
				burst_left--;
			else
				idle_sender(idle_len());
		end

		@(negedge clk);
		pix_in.valid <= 1'b0;

		while (blended_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------
	// Drain side: ready toggles in runs of flow and stall.
	// ---------------------------------------------------------------
	initial begin : drain_side
		int unsigned flow_left;
		int unsigned stall_left;
		pix_out.ready = 1'b0;
		flow_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				flow_left = 0;
				stall_left = HOLD_OFF;
			end
			if (flow_left > 0) begin
				pix_out.ready <= 1'b1;
				flow_left--;
			end else if (stall_left > 0) begin
				pix_out.ready <= 1'b0;
				stall_left--;
			end else begin
				pix_out.ready <= 1'b1;
				flow_left = $urandom_range(0, 24);
				stall_left = idle_len();
			end
		end
	end

	// ---------------------------------------------------------------
	// Output check, field by field against the oldest expectation.
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (blended_q.size() == 0) begin
				$error("output transaction with no pixel outstanding");
				mismatches++;
			end else begin
				want = blended_q.pop_front();
				check_field("out_red",   want.r, pix_out.out_red);
				check_field("out_green", want.g, pix_out.out_green);
				check_field("out_blue",  want.b, pix_out.out_blue);
				check_field("out_alpha", want.a, pix_out.out_alpha);
			end
		end
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		#(LIMIT_NS);
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/saob_pkg.sv
sv/saob_if.sv
sv/straight_alpha_over_blend.sv
sim/testbench.sv
